/* rtl/core/stm_pkg.sv */
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants for the soft threshold mask unit: pixel and register
// widths, register indexes, reset values and fixed-point sizes.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int PIX_W         = 8;
    localparam int CFG_W         = 11;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int FRAC_BITS_DEF = 10;

    // normalised position a is unsigned Q16, range 0..1.0 inclusive
    localparam int A_BITS = 16;
    localparam int QBITS  = A_BITS + 1;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 11'd512;
    localparam logic [CFG_W-1:0] SOFTNESS_RESET  = 11'd0;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_SOFTNESS  = 1'b1
    } stm_reg_t;

endpackage

/* rtl/core/stm_stream_if.sv */
// ----------------------------------------------------------------------------
// stm_stream_if
// Valid/ready channels of the soft threshold mask unit: one for the
// foreground confidence pixels going in, one for the mask pixels coming out.
// ----------------------------------------------------------------------------
interface stm_fg_if
    import stm_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] fg_level;

    modport source (output valid, output fg_level, input ready);
    modport sink   (input valid, input fg_level, output ready);
endinterface

interface stm_bg_if
    import stm_pkg::*;
    ;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] bg_level;

    modport source (output valid, output bg_level, input ready);
    modport sink   (input valid, input bg_level, output ready);
endinterface

/* rtl/core/soft_threshold_mask_unit.sv */
// ----------------------------------------------------------------------------
// soft_threshold_mask_unit
// Turns a foreground confidence pixel into a background mask pixel, using a
// hard threshold or a smoothstep across a soft band around the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   fg_in carries one fg_level per transaction, bg_out one bg_level per
//   transaction, in the same order. The APB port holds threshold_frac at
//   byte address 0 and softness_frac at byte address 4; write them only
//   while no pixel is in flight. Both read back as written.
//   Throughput: one pixel per clock while bg_out does not stall. The path
//   is a 23-stage pipeline, of which 17 stages form the restoring divider
//   that yields one quotient bit per stage for the normalised band
//   position; the smoothstep takes two multiplier stages.
//   Stall: while bg_out holds an untaken result, the whole pipeline
//   freezes and fg_in.ready drops; nothing is lost or repeated.
//   Reset: valid bits clear, threshold returns to one half and softness
//   to zero (hard mode).
// ----------------------------------------------------------------------------
module soft_threshold_mask_unit
    import stm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    stm_fg_if.sink             fg_in,
    stm_bg_if.source           bg_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int TW  = FRAC_BITS + 1;          // fraction up to one
    localparam int LW  = FRAC_BITS + 2;          // band end, half units
    localparam int DW  = FRAC_BITS + 9;          // 255 * band end
    localparam int NW  = DW + A_BITS;            // dividend
    localparam int CW  = (TW > CFG_W) ? TW : CFG_W;
    localparam int SQW = 2 * QBITS;
    localparam int KW  = A_BITS + 2;
    localparam int SW  = 3 * A_BITS + 1;
    localparam int YW  = SW + 8;

    localparam int ST_IN   = 0;
    localparam int ST_N    = ST_IN + 1;
    localparam int ST_DIV  = ST_N + 1;
    localparam int ST_SQ   = ST_DIV + QBITS + 1;
    localparam int ST_CUBE = ST_SQ + 1;
    localparam int ST_OUT  = ST_CUBE + 1;
    localparam int NS      = ST_OUT + 1;

    localparam logic [TW-1:0] ONE      = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [LW:0]   TWO_ONE  = {2'b01, {(FRAC_BITS+1){1'b0}}};
    localparam logic [KW-1:0] K3       = {2'b11, {A_BITS{1'b0}}};
    localparam logic [SW-1:0] S_ONE    = {1'b1, {(SW-1){1'b0}}};
    localparam logic [YW-1:0] Y_HALF   = {{9{1'b0}}, 1'b1, {(SW-2){1'b0}}};
    localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] threshold_frac_reg;
    logic [CFG_W-1:0] softness_frac_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_frac_reg <= THRESHOLD_RESET;
            softness_frac_reg  <= SOFTNESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (stm_reg_t'(paddr[2]))
                REG_THRESHOLD: threshold_frac_reg <= pwdata[CFG_W-1:0];
                REG_SOFTNESS:  softness_frac_reg  <= pwdata[CFG_W-1:0];
                default:       threshold_frac_reg <= threshold_frac_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (stm_reg_t'(paddr[2]))
            REG_THRESHOLD: prdata = PDATA_W'(threshold_frac_reg);
            REG_SOFTNESS:  prdata = PDATA_W'(softness_frac_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Band geometry, derived from the registers; stable while pixels flow
    // ------------------------------------------------------------------
    logic [CW-1:0]     thr_ext, soft_ext;
    logic [TW-1:0]     t_c, s_c;
    logic [LW-1:0]     two_t, lo2, hi2, band;
    logic [LW:0]       hi_sum;
    logic [LW+7:0]     band_x255, lo_x255;
    logic [TW+7:0]     t_x255;
    logic [DW-1:0]     d_next, lo255_next;
    logic [PIX_W-1:0]  limit_next;
    logic              hard_next;
    logic [DW-1:0]     d_reg, lo255_reg;
    logic [PIX_W-1:0]  limit_reg;
    logic              hard_reg;

    always_comb
    begin
        thr_ext  = CW'(threshold_frac_reg);
        soft_ext = CW'(softness_frac_reg);
        // saturate at one
        t_c      = (thr_ext > CW'(ONE)) ? ONE : thr_ext[TW-1:0];
        s_c      = (soft_ext > CW'(ONE)) ? ONE : soft_ext[TW-1:0];
        two_t    = {t_c, 1'b0};
        lo2      = (two_t >= LW'(s_c)) ? (two_t - LW'(s_c)) : '0;
        hi_sum   = (LW+1)'(two_t) + (LW+1)'(s_c);
        hi2      = (hi_sum > TWO_ONE) ? TWO_ONE[LW-1:0] : hi_sum[LW-1:0];
        band     = hi2 - lo2;
        band_x255  = {band, 8'd0} - (LW+8)'(band);
        lo_x255    = {lo2, 8'd0} - (LW+8)'(lo2);
        t_x255     = {t_c, 8'd0} - (TW+8)'(t_c);
        d_next     = band_x255[DW-1:0];
        lo255_next = lo_x255[DW-1:0];
        limit_next = t_x255[FRAC_BITS+PIX_W-1:FRAC_BITS];
        hard_next  = (s_c == '0) || (hi2 == lo2);
    end

    always_ff @(posedge clk)
    begin
        d_reg     <= d_next;
        lo255_reg <= lo255_next;
        limit_reg <= limit_next;
        hard_reg  <= hard_next;
    end

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipe advances together
    // ------------------------------------------------------------------
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic          adv;

    assign adv         = !valid_reg[ST_OUT] || bg_out.ready;
    assign fg_in.ready = adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = {valid_reg[NS-2:0], fg_in.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage and band position numerator
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] fg_reg;
    logic [DW-1:0]    fgx, diff, n_next, n_reg;
    logic             hit_next, n_hit_reg;

    always_comb
    begin
        fgx      = {fg_reg, {(FRAC_BITS+1){1'b0}}};
        diff     = fgx - lo255_reg;
        if (fgx <= lo255_reg)
        begin
            n_next = '0;
        end
        else if (diff > d_reg)
        begin
            n_next = d_reg;
        end
        else
        begin
            n_next = diff;
        end
        hit_next = fg_reg < limit_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fg_reg    <= fg_in.fg_level;
            n_reg     <= n_next;
            n_hit_reg <= hit_next;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: a = (n * 2^16 + d/2) / d, one quotient bit a stage
    // ------------------------------------------------------------------
    logic [DW-1:0]    div_rem_reg [0:QBITS];
    logic [QBITS-1:0] div_low_reg [0:QBITS];
    logic [QBITS-1:0] div_q_reg   [0:QBITS];
    logic             div_hit_reg [0:QBITS];
    logic [NW-1:0]    num_next;

    assign num_next = {n_reg, {A_BITS{1'b0}}} + NW'(d_reg >> 1);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_rem_reg[0] <= DW'(num_next[NW-1:QBITS]);
            div_low_reg[0] <= num_next[QBITS-1:0];
            div_q_reg[0]   <= '0;
            div_hit_reg[0] <= n_hit_reg;
        end
    end

    for (genvar k = 0; k < QBITS; k++)
    begin : g_div
        logic [DW:0]      trial;
        logic [DW:0]      trial_sub;
        logic             take;
        logic [DW-1:0]    rem_next;

        always_comb
        begin
            trial     = {div_rem_reg[k], div_low_reg[k][QBITS-1]};
            trial_sub = trial - {1'b0, d_reg};
            take      = trial >= {1'b0, d_reg};
            rem_next  = take ? trial_sub[DW-1:0] : trial[DW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[k+1] <= rem_next;
                div_low_reg[k+1] <= {div_low_reg[k][QBITS-2:0], 1'b0};
                div_q_reg[k+1]   <= {div_q_reg[k][QBITS-2:0], take};
                div_hit_reg[k+1] <= div_hit_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Smoothstep s = a * a * (3 - 2a), then 255 * (1 - s) rounded; hard mode gives 255 or 0
    // ------------------------------------------------------------------
    logic [QBITS-1:0]   a_val;
    logic [SQW-1:0]     sq_next, sq_reg;
    logic [KW-1:0]      k_next, k_reg;
    logic               sq_hit_reg;
    logic [SQW+KW-1:0]  cube_prod;
    logic [SW-1:0]      s_next, s_reg;
    logic               s_hit_reg;
    logic [SW-1:0]      inv_s;
    logic [YW-1:0]      y_val;
    logic [PIX_W-1:0]   bg_next, bg_reg;

    always_comb
    begin
        a_val     = div_q_reg[QBITS];
        sq_next   = SQW'(a_val) * SQW'(a_val);
        k_next    = K3 - {a_val, 1'b0};
        cube_prod = (SQW+KW)'(sq_reg) * (SQW+KW)'(k_reg);
        s_next    = cube_prod[SW-1:0];
        inv_s     = S_ONE - s_reg;
        y_val     = {inv_s, 8'd0} - YW'(inv_s) + Y_HALF;
        if (hard_reg)
        begin
            bg_next = s_hit_reg ? PIX_MAX : '0;
        end
        else
        begin
            bg_next = y_val[SW+PIX_W-2:SW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg     <= sq_next;
            k_reg      <= k_next;
            sq_hit_reg <= div_hit_reg[QBITS];
            s_reg      <= s_next;
            s_hit_reg  <= sq_hit_reg;
            bg_reg     <= bg_next;
        end
    end

    assign bg_out.valid    = valid_reg[ST_OUT];
    assign bg_out.bg_level = bg_reg;

endmodule

/* bench/soft_threshold_mask_unit_test.sv */
// ----------------------------------------------------------------------------
// soft_threshold_mask_unit_test
// Self-checking bench for the soft threshold mask unit. Pixels stream in
// and mask values stream out on the valid/ready channels, with random
// stalls on both sides. Every accepted pixel is scored against a bit-exact
// model of the hard threshold and smoothstep band. Threshold and softness
// are rewritten over APB between drained phases, extremes included.
// ----------------------------------------------------------------------------
module soft_threshold_mask_unit_test;
    import stm_pkg::*;

    localparam int PIPE_LATENCY = 22;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
    localparam int QUIET_LIMIT  = 2000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    stm_fg_if fg_if ();
    stm_bg_if bg_if ();

    soft_threshold_mask_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .fg_in   (fg_if),
        .bg_out  (bg_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [CFG_W-1:0] cfg_threshold = THRESHOLD_RESET;
    logic [CFG_W-1:0] cfg_softness  = SOFTNESS_RESET;
    logic [PIX_W-1:0] pending_bg[$];
    bit               idle_on = 1'b1;
    int               mismatch_count = 0;
    int               quiet_cycles = 0;
    int               sink_hold = 0;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Background mask level for one pixel under the current register copies
    function automatic logic [PIX_W-1:0] mask_level(input logic [PIX_W-1:0] fg);
        longint unsigned one_v, t, s, limit, nu, du, a16, s48, bg;
        longint          lo2, hi2, two_one, num, den, fg_v;
        one_v   = 64'd1 << FRAC_BITS_DEF;
        two_one = $signed(2 * one_v);
        t       = (64'(cfg_threshold) > one_v) ? one_v : 64'(cfg_threshold);
        s       = (64'(cfg_softness) > one_v) ? one_v : 64'(cfg_softness);
        limit   = (t * 255) >> FRAC_BITS_DEF;
        fg_v    = longint'(fg);
        lo2     = $signed(2 * t) - $signed(s);
        hi2     = $signed(2 * t) + $signed(s);
        if (lo2 < 0) lo2 = 0;
        if (lo2 > two_one) lo2 = two_one;
        if (hi2 < 0) hi2 = 0;
        if (hi2 > two_one) hi2 = two_one;
        if (s == 0 || hi2 <= lo2)
            return (64'(fg) < limit) ? 8'd255 : 8'd0;
        den = 255 * (hi2 - lo2);
        num = fg_v * two_one - 255 * lo2;
        if (num < 0) num = 0;
        if (num > den) num = den;
        nu  = num;
        du  = den;
        a16 = (nu * 64'd65536 + du / 2) / du;
        if (a16 > 64'd65536) a16 = 64'd65536;
        s48 = a16 * a16 * (64'd196608 - 2 * a16);
        if (s48 > (64'd1 << 48)) s48 = 64'd1 << 48;
        bg  = (255 * ((64'd1 << 48) - s48) + (64'd1 << 47)) >> 48;
        if (bg > 255) bg = 255;
        return bg[PIX_W-1:0];
    endfunction

    task automatic log_mismatch(input string what, input int exp_v, input int act_v);
        if (mismatch_count < 10)
            $display("mismatch (%0s): expected %0d, got %0d, threshold %0d softness %0d",
                     what, exp_v, act_v, cfg_threshold, cfg_softness);
        mismatch_count++;
    endtask

    // Score results, then record the expectation of each accepted pixel
    always @(posedge clk)
    begin
        logic [PIX_W-1:0] want;
        if (bg_if.valid && bg_if.ready)
        begin
            if (pending_bg.size() == 0)
                log_mismatch("unexpected transaction", -1, int'(bg_if.bg_level));
            else
            begin
                want = pending_bg.pop_front();
                if (bg_if.bg_level !== want)
                    log_mismatch("bg_level", int'(want), int'(bg_if.bg_level));
            end
        end
        if (fg_if.valid && fg_if.ready)
            pending_bg.push_back(mask_level(fg_if.fg_level));
    end

    // Output back-pressure in random bursts
    always @(posedge clk)
    begin
        if (!idle_on)
            bg_if.ready <= 1'b1;
        else if (sink_hold > 0)
        begin
            sink_hold--;
            bg_if.ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            sink_hold = int'($urandom_range(1, 14)) - 1;
            bg_if.ready <= 1'b0;
        end
        else
            bg_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((fg_if.valid && fg_if.ready) || (bg_if.valid && bg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one pixel and hold it until the transaction completes
    task automatic send_pixel(input logic [PIX_W-1:0] fg);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            fg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fg_if.valid    <= 1'b1;
        fg_if.fg_level <= fg;
        do @(posedge clk); while (!fg_if.ready);
    endtask

    // Drop valid and hold off until every pixel in flight has come out
    task automatic drain_pipe();
        fg_if.valid <= 1'b0;
        do @(posedge clk); while (pending_bg.size() != 0);
    endtask

    // Setup and access phases, then the bus returns to idle
    task automatic write_reg(input stm_reg_t idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_THRESHOLD)
            cfg_threshold = value;
        else
            cfg_softness = value;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr,
                              input logic [CFG_W-1:0] softness);
        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_SOFTNESS, softness);
    endtask

    // Reset leaves a hard threshold at one half: limit is 127
    task automatic test_hard_at_reset();
        send_pixel(8'd0);
        send_pixel(8'd126);
        send_pixel(8'd127);
        send_pixel(8'd128);
        send_pixel(8'd255);
    endtask

    // Register values above one behave as exactly one
    task automatic test_register_saturation();
        set_config(11'h7FF, 11'd0);
        send_pixel(8'd254);
        send_pixel(8'd255);
        set_config(11'd1024, 11'h7FF);
        send_pixel(8'd0);
        send_pixel(8'd128);
        send_pixel(8'd255);
    endtask

    task automatic test_soft_band_edges();
        // lower end clamps at zero
        set_config(11'd0, 11'd1024);
        send_pixel(8'd0);
        send_pixel(8'd64);
        send_pixel(8'd255);
        // narrowest band
        set_config(11'd512, 11'd1);
        send_pixel(8'd127);
        send_pixel(8'd128);
        set_config(11'd300, 11'd200);
        send_pixel(8'd0);
        send_pixel(8'd60);
        send_pixel(8'd75);
        send_pixel(8'd90);
        send_pixel(8'd255);
    endtask

    // Stop feeding mid-stream until the pipeline is empty, then resume
    task automatic test_drain_pause();
        repeat (60) send_pixel(8'($urandom_range(0, 255)));
        drain_pipe();
        repeat (60) send_pixel(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        logic [CFG_W-1:0] thr;
        logic [CFG_W-1:0] softness;
        int               centre;
        int               span;
        int               fg_i;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(0, 4))
                0:       thr = 11'd0;
                1:       thr = 11'd1024;
                2:       thr = 11'h7FF;
                default: thr = CFG_W'($urandom_range(0, 2047));
            endcase
            case ($urandom_range(0, 6))
                0:       softness = 11'd0;
                1:       softness = 11'd1;
                2:       softness = 11'd1024;
                3:       softness = 11'h7FF;
                default: softness = CFG_W'($urandom_range(0, 2047));
            endcase
            set_config(thr, softness);
            centre = ((thr > 1024) ? 1024 : int'(thr)) * 255 / 1024;
            span   = ((softness > 1024) ? 1024 : int'(softness)) * 255 / 2048 + 4;
            for (int k = 0; k < per_phase; k++)
            begin
                // aim most pixels at the band so the smoothstep gets exercised
                if ($urandom_range(0, 3) == 0)
                    fg_i = $urandom_range(0, 255);
                else
                    fg_i = centre - span + int'($urandom_range(0, 2 * span));
                if (fg_i < 0) fg_i = 0;
                if (fg_i > 255) fg_i = 255;
                send_pixel(8'(fg_i));
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        fg_if.valid    <= 1'b0;
        fg_if.fg_level <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_hard_at_reset();
        test_register_saturation();
        test_soft_band_edges();
        test_drain_pause();
        test_random_settings(12, 130);

        // full rate on both sides to finish
        idle_on = 1'b0;
        test_random_settings(1, 150);

        drain_pipe();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_bg.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
